@@ hdl/assert_macros.svh @@
// Assertion macros used by the escaper datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hdl/jse_pkg.sv @@
// Types, character constants and escape functions of the JSON string escaper.
package jse_pkg;

	typedef logic [20:0] cp_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_HEX_A  = 8'h57; // 'a' minus ten

	localparam cp_t CP_BS  = 21'h08;
	localparam cp_t CP_TAB = 21'h09;
	localparam cp_t CP_LF  = 21'h0a;
	localparam cp_t CP_FF  = 21'h0c;
	localparam cp_t CP_CR  = 21'h0d;
	localparam cp_t CP_CTRL_END = 21'h20;
	localparam cp_t CP_ASCII_END = 21'h80;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic put_open;
		logic feed;
		logic flush;
		logic emit;
		logic put_close;
		logic finish;
	} jse_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic q_empty;
		logic pend_empty;
		logic last;
		logic feed_emits;
		logic emit_last;
		logic prod_ok;
	} jse_sts_t;

	// Second character of a two-byte escape, zero when there is none.
	function automatic logic [7:0] esc_char(cp_t cp);
		logic [7:0] e;
		case (cp)
			21'h5c:  e = CH_BSLASH;
			21'h22:  e = CH_QUOTE;
			21'h2f:  e = CH_SLASH;
			CP_BS:   e = CH_B;
			CP_FF:   e = CH_F;
			CP_LF:   e = CH_N;
			CP_CR:   e = CH_R;
			CP_TAB:  e = CH_T;
			default: e = 8'h00;
		endcase
		return e;
	endfunction

	function automatic logic use_hex(cp_t cp, logic ascii);
		return (cp < CP_CTRL_END) || ((cp >= CP_ASCII_END) && ascii);
	endfunction

	function automatic logic [2:0] hex_digits(cp_t cp);
		logic [2:0] d;
		if (cp <= 21'h00ffff) d = 3'd4;
		else if (cp <= 21'h0fffff) d = 3'd5;
		else d = 3'd6;
		return d;
	endfunction

	// Number of output bytes for one code point.
	function automatic logic [3:0] emit_len(cp_t cp, logic ascii);
		logic [3:0] n;
		if (esc_char(cp) != 8'h00) n = 4'd2;
		else if (use_hex(cp, ascii)) n = 4'd2 + {1'b0, hex_digits(cp)};
		else if (cp < CP_ASCII_END) n = 4'd1;
		else if (cp < 21'h000800) n = 4'd2;
		else if (cp < 21'h010000) n = 4'd3;
		else n = 4'd4;
		return n;
	endfunction

	// Output byte number idx of the escaped form of one code point.
	function automatic logic [7:0] emit_byte(cp_t cp, logic ascii, logic [2:0] idx);
		logic [7:0] e;
		logic [7:0] b;
		logic [2:0] d;
		logic [3:0] nib;
		logic [31:0] cpx;
		e = esc_char(cp);
		// Pad to eight nibbles so every digit position stays in range.
		cpx = {11'b0, cp};
		d = hex_digits(cp) + 3'd1 - idx;
		nib = cpx[{d, 2'b00} +: 4];
		if (e != 8'h00) begin
			b = (idx == 3'd0) ? CH_BSLASH : e;
		end else if (use_hex(cp, ascii)) begin
			if (idx == 3'd0) b = CH_BSLASH;
			else if (idx == 3'd1) b = CH_U;
			else if (nib < 4'd10) b = CH_ZERO + {4'b0000, nib};
			else b = CH_HEX_A + {4'b0000, nib};
		end else if (cp < CP_ASCII_END) begin
			b = cp[7:0];
		end else if (cp < 21'h000800) begin
			b = (idx == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
		end else if (cp < 21'h010000) begin
			case (idx)
				3'd0:    b = {4'b1110, cp[15:12]};
				3'd1:    b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[5:0]};
			endcase
		end else begin
			case (idx)
				3'd0:    b = {5'b11110, cp[20:18]};
				3'd1:    b = {2'b10, cp[17:12]};
				3'd2:    b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[5:0]};
			endcase
		end
		return b;
	endfunction

endpackage

@@ hdl/jse_ctrl.sv @@
// Controller state machine of the JSON string escaper.
module jse_ctrl
	import jse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      first_byte,
	output logic      in_stall,
	input  jse_sts_t  sts,
	output jse_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_FEED,
		ST_EMIT,
		ST_CLOSE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid && !in_stall_q;
			ST_OPEN:   cmd.put_open = sts.prod_ok;
			ST_FEED: begin
				if (!sts.q_empty) cmd.feed = 1'b1;
				else if (sts.last && !sts.pend_empty) cmd.flush = 1'b1;
			end
			ST_EMIT:   cmd.emit = sts.prod_ok;
			ST_CLOSE:  cmd.put_close = sts.prod_ok;
			ST_FINISH: cmd.finish = sts.prod_ok;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						in_stall_q <= 1'b1;
						state_q    <= first_byte ? ST_OPEN : ST_FEED;
					end
				end
				ST_OPEN: begin
					if (cmd.put_open) state_q <= ST_FEED;
				end
				ST_FEED: begin
					if (cmd.feed) begin
						if (sts.feed_emits) state_q <= ST_EMIT;
					end else if (cmd.flush) begin
						state_q <= ST_EMIT;
					end else if (sts.last) begin
						state_q <= ST_CLOSE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_EMIT: begin
					if (cmd.emit && sts.emit_last) state_q <= ST_FEED;
				end
				ST_CLOSE: begin
					if (cmd.put_close) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.finish) begin
						in_stall_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/jse_datapath.sv @@
// Datapath of the JSON string escaper: UTF-8 decoder, byte queue, emitter, output stage.
`include "assert_macros.svh"

module jse_datapath
	import jse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic [7:0] in_byte,
	input  logic      first_byte,
	input  logic      last_byte,
	input  jse_cmd_t  cmd,
	output jse_sts_t  sts,
	output logic      out_valid,
	input  logic      out_stall,
	output logic [7:0] out_byte,
	output logic      run_last,
	output logic      string_done
);

	// Configuration and decoder state.
	logic       ascii_q;
	logic [7:0] pend_q [3];
	logic [1:0] pcnt_q;
	logic [2:0] elen_q;
	cp_t        pcp_q;

	// Bytes waiting to be fed to the decoder.
	logic [7:0] q_q [3];
	logic [1:0] qcnt_q;
	logic       last_q;

	// Code point being written out.
	cp_t        cp_q;
	logic [2:0] eidx_q;

	// One-word hold so the final word of a step can carry run_last.
	logic       hold_v_q;
	logic [7:0] hold_byte_q;
	logic       hold_done_q;

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       done_q;

	logic [7:0] head;
	logic       lead2, lead3, lead4, is_lead;
	logic [7:0] lo, hi;
	logic       cont_ok, complete, feed_emits;
	cp_t        joined_cp;
	logic       can_push, prod_ok, put;
	logic [7:0] put_byte;

	always_comb begin
		head  = q_q[0];
		lead2 = (head >= 8'hc2) && (head <= 8'hdf);
		lead3 = (head >= 8'he0) && (head <= 8'hef);
		lead4 = (head >= 8'hf0) && (head <= 8'hf4);
		is_lead = lead2 || lead3 || lead4;
		lo = 8'h80;
		hi = 8'hbf;
		// Second byte of a three- or four-byte form has a narrower range.
		if (pcnt_q == 2'd1) begin
			case (pend_q[0])
				8'he0:   lo = 8'ha0;
				8'hed:   hi = 8'h9f;
				8'hf0:   lo = 8'h90;
				8'hf4:   hi = 8'h8f;
				default: ;
			endcase
		end
		cont_ok   = (head >= lo) && (head <= hi);
		joined_cp = {pcp_q[14:0], head[5:0]};
		complete  = (({1'b0, pcnt_q} + 3'd1) >= elen_q) || (pcnt_q == 2'd3);
		feed_emits = (pcnt_q == 2'd0) ? !is_lead : (!cont_ok || complete);
	end

	assign can_push = !out_v_q || !out_stall;
	assign prod_ok  = !hold_v_q || can_push;
	assign put      = cmd.put_open || cmd.emit || cmd.put_close;
	assign put_byte = (cmd.put_open || cmd.put_close) ? CH_QUOTE
		: emit_byte(cp_q, ascii_q, eidx_q);

	always_comb begin
		sts.q_empty    = (qcnt_q == 2'd0);
		sts.pend_empty = (pcnt_q == 2'd0);
		sts.last       = last_q;
		sts.feed_emits = feed_emits;
		sts.emit_last  = ({1'b0, eidx_q} == (emit_len(cp_q, ascii_q) - 4'd1));
		sts.prod_ok    = prod_ok;
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_q  <= 1'b0;
			pcnt_q   <= 2'd0;
			elen_q   <= 3'd0;
			pcp_q    <= '0;
			qcnt_q   <= 2'd0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) ascii_q <= cfg_wr_data;

			if (cmd.load) begin
				qcnt_q <= 2'd1;
				if (first_byte) begin
					pcnt_q <= 2'd0;
					elen_q <= 3'd0;
					pcp_q  <= '0;
				end
			end else if (cmd.feed) begin
				if (pcnt_q == 2'd0) begin
					qcnt_q <= qcnt_q - 2'd1;
					if (is_lead) begin
						pcnt_q <= 2'd1;
						if (lead2) begin
							elen_q <= 3'd2;
							pcp_q  <= {16'b0, head[4:0]};
						end else if (lead3) begin
							elen_q <= 3'd3;
							pcp_q  <= {17'b0, head[3:0]};
						end else begin
							elen_q <= 3'd4;
							pcp_q  <= {18'b0, head[2:0]};
						end
					end
				end else if (cont_ok) begin
					qcnt_q <= qcnt_q - 2'd1;
					if (complete) begin
						pcnt_q <= 2'd0;
						elen_q <= 3'd0;
						pcp_q  <= '0;
					end else begin
						pcnt_q <= pcnt_q + 2'd1;
						pcp_q  <= joined_cp;
					end
				end else begin
					// Drop the lead byte to Latin-1, rescan the rest ahead of the queue.
					qcnt_q <= qcnt_q + pcnt_q - 2'd1;
					pcnt_q <= 2'd0;
					elen_q <= 3'd0;
					pcp_q  <= '0;
				end
			end else if (cmd.flush) begin
				qcnt_q <= pcnt_q - 2'd1;
				pcnt_q <= 2'd0;
				elen_q <= 3'd0;
				pcp_q  <= '0;
			end

			if (put) hold_v_q <= 1'b1;
			else if (cmd.finish) hold_v_q <= 1'b0;

			if ((put || cmd.finish) && hold_v_q) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q[0] <= in_byte;
			last_q <= last_byte;
		end else if (cmd.feed) begin
			eidx_q <= 3'd0;
			if (pcnt_q == 2'd0) begin
				q_q[0] <= q_q[1];
				q_q[1] <= q_q[2];
				if (is_lead) pend_q[0] <= head;
				else cp_q <= {13'b0, head};
			end else if (cont_ok) begin
				q_q[0] <= q_q[1];
				q_q[1] <= q_q[2];
				if (complete) cp_q <= joined_cp;
				else pend_q[pcnt_q] <= head;
			end else begin
				cp_q <= {13'b0, pend_q[0]};
				if (pcnt_q == 2'd2) begin
					q_q[0] <= pend_q[1];
					q_q[1] <= q_q[0];
					q_q[2] <= q_q[1];
				end else if (pcnt_q == 2'd3) begin
					q_q[0] <= pend_q[1];
					q_q[1] <= pend_q[2];
					q_q[2] <= q_q[0];
				end
			end
		end else if (cmd.flush) begin
			cp_q   <= {13'b0, pend_q[0]};
			eidx_q <= 3'd0;
			q_q[0] <= pend_q[1];
			q_q[1] <= pend_q[2];
		end else if (cmd.emit) begin
			eidx_q <= eidx_q + 3'd1;
		end

		if ((put || cmd.finish) && hold_v_q) begin
			out_byte_q <= hold_byte_q;
			run_last_q <= cmd.finish;
			done_q     <= hold_done_q;
		end
		if (put) begin
			hold_byte_q <= put_byte;
			hold_done_q <= cmd.put_close;
		end
	end

	assign out_valid   = out_v_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign string_done = done_q;

	`ASSERT_AT(a_pend_below_len, clk, arst_n, (pcnt_q != 2'd0) |-> ({1'b0, pcnt_q} < elen_q), "pending count reached expected length")
	`ASSERT_AT(a_rescan_fits, clk, arst_n, (cmd.feed && (pcnt_q == 2'd3) && !cont_ok) |-> (qcnt_q <= 2'd1), "rescan overflows byte queue")
	`ASSERT_AT(a_finish_drains, clk, arst_n, cmd.finish |=> !hold_v_q, "held word left after step end")
	`ASSERT_NEVER(a_push_blocked, clk, arst_n, (put || cmd.finish) && hold_v_q && out_v_q && out_stall, "word pushed into stalled output")

endmodule

@@ hdl/json_string_escaper.sv @@
// Top level of the JSON string escaper: controller plus datapath.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid in_stall in_byte first_byte last_byte | raw source bytes, one a word
//   out     | out_valid out_stall out_byte run_last string_done | escaped literal bytes
//   cfg     | cfg_wr_en cfg_wr_data                     | ascii_only register write
//
// One input word is accepted, then given one decoder step per byte fed or rescanned and
// per pending lead dropped at the end of a string, one emit per output byte (quotes
// included), a check that finds the byte queue empty, and a close-out of the step.
// Decode steps take a single byte; the emitter gives one byte a cycle unless stalled.
// Reset is asynchronous, active low; it clears the decoder, queue and output stage.
// A stalled output holds its word; production waits only once the hold word is full.
// in_stall is high from acceptance until the step's last word has been handed on.
module json_string_escaper
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done
);

	jse_cmd_t cmd;
	jse_sts_t sts;

	// Sequence the step: open quote, decode, emit, flush, close quote.
	jse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.first_byte (first_byte),
		.in_stall   (in_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Decode UTF-8, rescan bad sequences, expand escapes, drive the output word.
	jse_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_byte     (in_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule

@@ dv/json_string_escaper_tb.sv @@
// Self-checking testbench of the JSON string escaper: random UTF-8 strings, predicted literal.
`timescale 1ns / 1ps

module json_string_escaper_tb;
	import jse_pkg::*;

	// Give up well beyond the slowest correct run.
	localparam int LIMIT_CYCLES = 2000000;
	// Quiet time after the last expected word.
	localparam int DRAIN_CYCLES = 64;
	// Random input words per random phase.
	localparam int PHASE_WORDS = 150;
	// Long receiver hold-off, in cycles, and the input count that starts it.
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AT = 100;
	localparam int MAX_PRINTED = 50;

	localparam logic [7:0] HEX_DIGIT_0 = "0";
	localparam logic [7:0] HEX_DIGIT_A = "a";

	// Configuration settings of the ascii_only register.
	localparam logic MODE_UTF8 = 1'b0;
	localparam logic MODE_ASCII = 1'b1;

	typedef struct packed {
		logic [7:0] b;
		logic       f;
		logic       l;
	} src_word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       rl;
		logic       sd;
	} lit_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       first_byte = 1'b0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	json_string_escaper dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_done (string_done)
	);

	// Source words waiting for the driver, and literal words waiting for the monitor.
	src_word_t src_q[$];
	lit_word_t lit_q[$];

	// Escaper copy: mode register and decoder state, updated as words are accepted.
	logic       ascii_mode = MODE_UTF8;
	logic [7:0] pend_bytes [0:2];
	logic [1:0] pend_cnt = 2'd0;
	logic [2:0] seq_len = 3'd0;
	cp_t        partial_cp = '0;
	logic [7:0] rescan_q[$];
	lit_word_t  step_q[$];

	int cycles = 0;
	int err_count = 0;
	int n_in = 0;
	int n_out = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	// ------------------------------------------------------------------
	// Literal predictor
	// ------------------------------------------------------------------

	function automatic void put_lit(input logic [7:0] b);
		lit_word_t w;
		w.b = b;
		w.rl = 1'b0;
		w.sd = 1'b0;
		step_q.push_back(w);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? HEX_DIGIT_0 + {4'b0000, nib}
			: HEX_DIGIT_A + {4'b0000, nib} - 8'd10;
	endfunction

	// Write one code point in its escaped or re-encoded form.
	function automatic void write_cp(input cp_t cp);
		logic [7:0]  esc;
		logic [23:0] cpx;
		logic [23:0] sh;
		int          nd;
		int          d;
		esc = 8'h00;
		cpx = {3'b000, cp};
		case (cp)
			{13'd0, CH_BSLASH}: esc = CH_BSLASH;
			{13'd0, CH_QUOTE}:  esc = CH_QUOTE;
			{13'd0, CH_SLASH}:  esc = CH_SLASH;
			CP_BS:              esc = CH_B;
			CP_FF:              esc = CH_F;
			CP_LF:              esc = CH_N;
			CP_CR:              esc = CH_R;
			CP_TAB:             esc = CH_T;
			default:            esc = 8'h00;
		endcase
		if (esc != 8'h00) begin
			put_lit(CH_BSLASH);
			put_lit(esc);
		end else if (cp < CP_CTRL_END || (cp >= CP_ASCII_END && ascii_mode)) begin
			// Four hex digits, five or six above the basic plane.
			nd = (cp <= 21'h00ffff) ? 4 : ((cp <= 21'h0fffff) ? 5 : 6);
			put_lit(CH_BSLASH);
			put_lit(CH_U);
			for (d = nd - 1; d >= 0; d--) begin
				sh = cpx >> (4 * d);
				put_lit(hex_char(sh[3:0]));
			end
		end else if (cp < CP_ASCII_END) begin
			put_lit(cp[7:0]);
		end else if (cp < 21'h000800) begin
			put_lit({3'b110, cp[10:6]});
			put_lit({2'b10, cp[5:0]});
		end else if (cp < 21'h010000) begin
			put_lit({4'b1110, cp[15:12]});
			put_lit({2'b10, cp[11:6]});
			put_lit({2'b10, cp[5:0]});
		end else begin
			put_lit({5'b11110, cp[20:18]});
			put_lit({2'b10, cp[17:12]});
			put_lit({2'b10, cp[11:6]});
			put_lit({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void clear_seq();
		pend_cnt = 2'd0;
		seq_len = 3'd0;
		partial_cp = '0;
	endfunction

	// Allowed range of the next continuation byte; the second byte depends on the lead.
	function automatic logic cont_fits(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hbf;
		if (pend_cnt == 2'd1) begin
			if (pend_bytes[0] == 8'he0) lo = 8'ha0;
			else if (pend_bytes[0] == 8'hed) hi = 8'h9f;
			else if (pend_bytes[0] == 8'hf0) lo = 8'h90;
			else if (pend_bytes[0] == 8'hf4) hi = 8'h8f;
		end
		return b >= lo && b <= hi;
	endfunction

	// Drain the rescan queue through the decoder. A broken sequence gives up its lead
	// as Latin-1 and puts the bytes after it back at the head of the queue.
	function automatic void decode_rescan();
		logic [7:0] b;
		logic [7:0] lead;
		cp_t        cp;
		int         k;
		while (rescan_q.size() > 0) begin
			b = rescan_q.pop_front();
			if (pend_cnt == 2'd0) begin
				if (b < 8'h80) begin
					write_cp({13'd0, b});
				end else if (b >= 8'hc2 && b <= 8'hdf) begin
					pend_bytes[0] = b;
					pend_cnt = 2'd1;
					seq_len = 3'd2;
					partial_cp = {16'd0, b[4:0]};
				end else if (b >= 8'he0 && b <= 8'hef) begin
					pend_bytes[0] = b;
					pend_cnt = 2'd1;
					seq_len = 3'd3;
					partial_cp = {17'd0, b[3:0]};
				end else if (b >= 8'hf0 && b <= 8'hf4) begin
					pend_bytes[0] = b;
					pend_cnt = 2'd1;
					seq_len = 3'd4;
					partial_cp = {18'd0, b[2:0]};
				end else begin
					write_cp({13'd0, b});
				end
			end else if (cont_fits(b)) begin
				partial_cp = {partial_cp[14:0], b[5:0]};
				if ({1'b0, pend_cnt} + 3'd1 >= seq_len || pend_cnt == 2'd3) begin
					cp = partial_cp;
					clear_seq();
					write_cp(cp);
				end else begin
					pend_bytes[pend_cnt] = b;
					pend_cnt = pend_cnt + 2'd1;
				end
			end else begin
				rescan_q.push_front(b);
				for (k = int'(pend_cnt) - 1; k >= 1; k--)
					rescan_q.push_front(pend_bytes[k]);
				lead = pend_bytes[0];
				clear_seq();
				write_cp({13'd0, lead});
			end
		end
	endfunction

	// End of string: give up pending leads one at a time and rescan what follows.
	function automatic void flush_seq();
		logic [7:0] lead;
		int         k;
		while (pend_cnt != 2'd0) begin
			for (k = int'(pend_cnt) - 1; k >= 1; k--)
				rescan_q.push_front(pend_bytes[k]);
			lead = pend_bytes[0];
			clear_seq();
			write_cp({13'd0, lead});
			decode_rescan();
		end
	endfunction

	// Work out the literal words of one accepted source word and queue them.
	function automatic void predict_literal(input logic [7:0] b, input logic f, input logic l);
		lit_word_t w;
		step_q.delete();
		if (f) begin
			clear_seq();
			put_lit(CH_QUOTE);
		end
		rescan_q.push_back(b);
		decode_rescan();
		if (l) begin
			flush_seq();
			put_lit(CH_QUOTE);
			w = step_q.pop_back();
			w.sd = 1'b1;
			step_q.push_back(w);
		end
		if (step_q.size() > 0) begin
			w = step_q.pop_back();
			w.rl = 1'b1;
			step_q.push_back(w);
		end
		while (step_q.size() > 0)
			lit_q.push_back(step_q.pop_front());
	endfunction

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(2, 1);
		if (r < 97) return $urandom_range(8, 3);
		return $urandom_range(40, 20);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTED)
			$display("mismatch at cycle %0d, word %0d: %s", cycles, n_out, msg);
		err_count++;
	endtask

	task automatic push_word(input logic [7:0] b, input logic f, input logic l);
		src_word_t s;
		s.b = b;
		s.f = f;
		s.l = l;
		src_q.push_back(s);
	endtask

	// Queue one string: mostly well-formed UTF-8 with random content, some noise and
	// broken or truncated sequences, and now and then a missing start or end mark.
	task automatic queue_random_string(inout int n_queued);
		logic [7:0] bytes[$];
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		int         n_ch;
		int         c;
		int         cls;
		int         k;
		int         n_cont;
		logic       f;
		logic       l;
		n_ch = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(14, 7);
		for (c = 0; c < n_ch; c++) begin
			cls = $urandom_range(99);
			if (cls < 30) begin
				bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
			end else if (cls < 40) begin
				case ($urandom_range(3))
					0: bytes.push_back(8'($urandom_range(8'h1f, 8'h00)));
					1: bytes.push_back(($urandom_range(2) == 0) ? CH_QUOTE
						: (($urandom_range(1) == 0) ? CH_BSLASH : CH_SLASH));
					2: bytes.push_back(CP_BS[7:0] + 8'($urandom_range(5)));
					default: bytes.push_back(($urandom_range(1) == 0) ? 8'h7f : 8'h20);
				endcase
			end else if (cls < 92 && cls >= 82) begin
				bytes.push_back(8'($urandom_range(255)));
			end else begin
				// Multi-byte sequence, complete unless broken.
				if (cls < 55) lead = 8'($urandom_range(8'hdf, 8'hc2));
				else if (cls < 70) lead = 8'($urandom_range(8'hef, 8'he0));
				else if (cls < 82) lead = 8'($urandom_range(8'hf4, 8'hf0));
				else lead = 8'($urandom_range(8'hf4, 8'hc2));
				n_cont = (lead >= 8'hf0) ? 3 : ((lead >= 8'he0) ? 2 : 1);
				if (cls >= 92) n_cont = $urandom_range(n_cont - 1);
				lo = 8'h80;
				hi = 8'hbf;
				if (lead == 8'he0) lo = 8'ha0;
				else if (lead == 8'hed) hi = 8'h9f;
				else if (lead == 8'hf0) lo = 8'h90;
				else if (lead == 8'hf4) hi = 8'h8f;
				bytes.push_back(lead);
				for (k = 0; k < n_cont; k++) begin
					if (k == 0) bytes.push_back(8'($urandom_range(hi, lo)));
					else bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
				end
				// A broken one is followed by any byte at all.
				if (cls >= 92) bytes.push_back(8'($urandom_range(255)));
			end
		end
		f = ($urandom_range(9) != 0);
		l = ($urandom_range(9) != 0);
		for (k = 0; k < bytes.size(); k++)
			push_word(bytes[k], f && k == 0, l && k == bytes.size() - 1);
		n_queued += bytes.size();
	endtask

	task automatic queue_random_phase();
		int n_queued;
		n_queued = 0;
		while (n_queued < PHASE_WORDS)
			queue_random_string(n_queued);
	endtask

	// Hold until the sender is empty, every expected word has come, and the block is quiet.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (src_q.size() != 0 || in_valid || lit_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, timeout
	// ------------------------------------------------------------------

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, lit_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: present queued source words, hold them while stalled, and
	// predict each word at the edge that accepts it.
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		src_word_t s;
		bit        take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			first_byte <= 1'b0;
			last_byte <= 1'b0;
			ascii_mode = MODE_UTF8;
			clear_seq();
			tx_gap = 0;
		end else begin
			take = in_valid && !in_stall;
			if (cfg_wr_en)
				ascii_mode = cfg_wr_data;
			if (take) begin
				predict_literal(in_byte, first_byte, last_byte);
				n_in <= n_in + 1;
				// Switch now and then between gapped traffic and back-to-back bursts.
				if ($urandom_range(39) == 0)
					tx_burst = !tx_burst;
				tx_gap = tx_burst ? 0 : pick_gap();
			end
			// A stalled word stays put; otherwise advance to a gap or the next word.
			if (!in_valid || take) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (src_q.size() > 0) begin
					s = src_q.pop_front();
					in_valid <= 1'b1;
					in_byte <= s.b;
					first_byte <= s.f;
					last_byte <= s.l;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random stalls, plus one long hold-off while the sender
	// keeps offering words, so the block backs up and stalls its input.
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
		end else begin
			if (!hold_done && n_in >= LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if ($urandom_range(199) == 0)
				rx_burst = !rx_burst;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (rx_burst) begin
				out_stall <= 1'b0;
			end else begin
				rx_gap = pick_gap();
				out_stall <= (rx_gap > 0);
				if (rx_gap > 0)
					rx_gap--;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check every accepted literal word against the oldest expectation.
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		lit_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (lit_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h", out_byte));
			end else begin
				w = lit_q.pop_front();
				if (out_byte !== w.b)
					report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, w.b));
				if (run_last !== w.rl)
					report_mismatch($sformatf("run_last %b, want %b", run_last, w.rl));
				if (string_done !== w.sd)
					report_mismatch($sformatf("string_done %b, want %b", string_done, w.sd));
			end
			n_out <= n_out + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, UTF-8 mode from reset: named escapes, controls, sequence extremes,
		// Latin-1 fallback, broken continuations, and a new string dropping a pending lead.
		push_word(8'h00, 1'b1, 1'b0);
		push_word(CH_QUOTE, 1'b0, 1'b0);
		push_word(CH_BSLASH, 1'b0, 1'b0);
		push_word(CH_SLASH, 1'b0, 1'b0);
		push_word(CP_BS[7:0], 1'b0, 1'b0);
		push_word(CP_FF[7:0], 1'b0, 1'b0);
		push_word(CP_LF[7:0], 1'b0, 1'b0);
		push_word(CP_CR[7:0], 1'b0, 1'b0);
		push_word(CP_TAB[7:0], 1'b0, 1'b0);
		push_word(8'h1f, 1'b0, 1'b0);
		push_word(8'h7f, 1'b0, 1'b0);
		push_word(8'hc2, 1'b0, 1'b0);
		push_word(8'h80, 1'b0, 1'b0);
		push_word(8'hf4, 1'b0, 1'b0);
		push_word(8'h8f, 1'b0, 1'b0);
		push_word(8'hbf, 1'b0, 1'b0);
		push_word(8'hbf, 1'b0, 1'b0);
		push_word(8'hff, 1'b0, 1'b0);
		push_word(8'he0, 1'b0, 1'b0);
		push_word(8'h80, 1'b0, 1'b0);
		push_word(8'hf0, 1'b0, 1'b0);
		push_word(8'h90, 1'b0, 1'b0);
		push_word(8'h41, 1'b0, 1'b0);
		push_word(8'he2, 1'b0, 1'b0);
		push_word(8'h41, 1'b1, 1'b1);
		wait_idle();

		// ASCII mode: highest code point as six hex digits, then random strings.
		// The long receiver hold-off falls in this phase.
		write_mode(MODE_ASCII);
		push_word(8'hf4, 1'b1, 1'b0);
		push_word(8'h8f, 1'b0, 1'b0);
		push_word(8'hbf, 1'b0, 1'b0);
		push_word(8'hbf, 1'b0, 1'b1);
		queue_random_phase();
		wait_idle();

		write_mode(MODE_UTF8);
		queue_random_phase();
		wait_idle();

		write_mode(MODE_ASCII);
		queue_random_phase();
		wait_idle();

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
